@@ sv/pll_register_word_generator_assert.svh @@
// Assertion macros used by the PLL register word generator datapath
`ifndef PLL_REGISTER_WORD_GENERATOR_ASSERT_SVH
`define PLL_REGISTER_WORD_GENERATOR_ASSERT_SVH

// Check cons in the same cycle as ante
`define PRWG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check cons in the cycle after ante
`define PRWG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/prwg_pkg.sv @@
// Types, constants and control program of the PLL register word generator
`default_nettype none

package prwg_pkg;

  localparam int FREQ_W  = 23;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 3;
  localparam int REFD_W  = 10;
  localparam int QUOT_W  = 13;
  localparam int REM_W   = 10;
  localparam int NUM_REGS = 6;

  localparam logic [FREQ_W-1:0] FREQ_MAX = 23'd4400000;
  localparam logic [FREQ_W-1:0] THR_64   = 23'd69000;
  localparam logic [FREQ_W-1:0] THR_32   = 23'd138000;
  localparam logic [FREQ_W-1:0] THR_16   = 23'd275000;
  localparam logic [FREQ_W-1:0] THR_8    = 23'd550000;
  localparam logic [FREQ_W-1:0] THR_4    = 23'd1100000;
  localparam logic [FREQ_W-1:0] THR_2    = 23'd2200000;

  // floor(x / 1000) == (x * RECIP) >> DIV_SHIFT for every 23-bit x
  localparam int              DIV_SHIFT = 33;
  localparam logic [23:0]     RECIP     = 24'd8589935;
  localparam logic [REM_W-1:0] MODULUS  = 10'd1000;

  localparam logic [REFD_W-1:0] REFD_RESET = 10'd10;

  localparam logic [WORD_W-1:0] REG5_WORD  = 32'h0058_0005;
  localparam logic [WORD_W-1:0] REG4_BASE  = 32'h0000_803C;
  localparam logic [WORD_W-1:0] REG3_WORD  = 32'h0000_1F43;
  localparam logic [WORD_W-1:0] REG2_BASE  = 32'h0000_2E42;
  localparam logic [WORD_W-1:0] REG1_WORD  = 32'h0800_9F41;

  localparam logic [IDX_W-1:0] IDX_R0 = 3'd0;
  localparam logic [IDX_W-1:0] IDX_R1 = 3'd1;
  localparam logic [IDX_W-1:0] IDX_R2 = 3'd2;
  localparam logic [IDX_W-1:0] IDX_R3 = 3'd3;
  localparam logic [IDX_W-1:0] IDX_R4 = 3'd4;
  localparam logic [IDX_W-1:0] IDX_R5 = 3'd5;

  localparam logic [3:0] CODE_DIV64 = 4'hE;
  localparam logic [3:0] CODE_DIV32 = 4'hD;
  localparam logic [3:0] CODE_DIV16 = 4'hC;
  localparam logic [3:0] CODE_DIV8  = 4'hB;
  localparam logic [3:0] CODE_DIV4  = 4'hA;
  localparam logic [3:0] CODE_DIV2  = 4'h9;
  localparam logic [3:0] CODE_DIV1  = 4'h8;

  typedef logic [1:0] step_t;

  localparam step_t STEP_TAKE = 2'd0;
  localparam step_t STEP_QUOT = 2'd1;
  localparam step_t STEP_REM  = 2'd2;
  localparam step_t STEP_EMIT = 2'd3;

  typedef enum logic [1:0] {
    JMP_NEVER,
    JMP_NO_BEAT,
    JMP_EMIT_MORE
  } jmp_e;

  typedef struct packed {
    logic  take_in;
    logic  ld_quot;
    logic  ld_rem;
    logic  emit;
    jmp_e  jmp;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic beat_in;
    logic emit_more;
  } stat_t;

  // Control program; the step after STEP_EMIT wraps to STEP_TAKE
  function automatic ctrl_t prog_rom(step_t s);
    ctrl_t c;
    c = '{take_in: 1'b0, ld_quot: 1'b0, ld_rem: 1'b0, emit: 1'b0,
          jmp: JMP_NEVER, target: STEP_TAKE};
    unique case (s)
      STEP_TAKE: begin
        c.take_in = 1'b1;
        c.jmp     = JMP_NO_BEAT;
        c.target  = STEP_TAKE;
      end
      STEP_QUOT: begin
        c.ld_quot = 1'b1;
      end
      STEP_REM: begin
        c.ld_rem = 1'b1;
      end
      STEP_EMIT: begin
        c.emit   = 1'b1;
        c.jmp    = JMP_EMIT_MORE;
        c.target = STEP_EMIT;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/prwg_sequencer.sv @@
// Step counter and control table of the PLL register word generator
`default_nettype none

module prwg_sequencer
  import prwg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  step_t step_q, step_d;
  ctrl_t ctrl;
  step_t step_inc;

  assign ctrl     = prog_rom(step_q);
  assign ctrl_o   = ctrl;
  assign step_inc = step_q + step_t'(1);

  always_comb begin
    unique case (ctrl.jmp)
      JMP_NEVER:     step_d = step_inc;
      JMP_NO_BEAT:   step_d = stat_i.beat_in ? step_inc : ctrl.target;
      JMP_EMIT_MORE: step_d = stat_i.emit_more ? ctrl.target : step_inc;
      default:       step_d = step_inc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_TAKE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/prwg_datapath.sv @@
// Divider select, oscillator split, word build and shadow compare of the PLL word generator
`default_nettype none

`include "pll_register_word_generator_assert.svh"

module prwg_datapath
  import prwg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  output stat_t             stat_o,
  input  logic              in_valid_i,
  input  logic [FREQ_W-1:0] freq_i,
  input  logic              cfg_we_i,
  input  logic [REFD_W-1:0] cfg_wdata_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [WORD_W-1:0] out_word_o,
  output logic [IDX_W-1:0]  out_idx_o,
  output logic              out_last_o
);

  logic [REFD_W-1:0] refd_q;
  logic [FREQ_W-1:0] osc_q;
  logic [3:0]        code_q;
  logic [QUOT_W-1:0] quot_q;
  logic [REM_W-1:0]  rem_q;
  logic [IDX_W-1:0]  idx_q;
  logic              writing_q;
  logic [WORD_W-1:0] shadow_q [NUM_REGS];

  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_last_q;

  logic [FREQ_W-1:0] freq_sat;
  logic [2:0]        shamt;
  logic [3:0]        code_d;
  logic [FREQ_W+5:0] osc_wide;
  logic [46:0]       prod;
  logic [FREQ_W-1:0] rem_full;
  logic [WORD_W-1:0] word;
  logic              beat_in;
  logic              need;
  logic              out_free;
  logic              advance;
  logic              load_out;

  assign beat_in = in_valid_i && ctrl_i.take_in;

  always_comb begin
    freq_sat = (freq_i > FREQ_MAX) ? FREQ_MAX : freq_i;
    priority if (freq_sat < THR_64) begin
      shamt = 3'd6; code_d = CODE_DIV64;
    end else if (freq_sat < THR_32) begin
      shamt = 3'd5; code_d = CODE_DIV32;
    end else if (freq_sat < THR_16) begin
      shamt = 3'd4; code_d = CODE_DIV16;
    end else if (freq_sat < THR_8) begin
      shamt = 3'd3; code_d = CODE_DIV8;
    end else if (freq_sat < THR_4) begin
      shamt = 3'd2; code_d = CODE_DIV4;
    end else if (freq_sat < THR_2) begin
      shamt = 3'd1; code_d = CODE_DIV2;
    end else begin
      shamt = 3'd0; code_d = CODE_DIV1;
    end
    osc_wide = {6'b0, freq_sat} << shamt;
  end

  assign prod     = 47'(osc_q) * 47'(RECIP);
  assign rem_full = osc_q - (FREQ_W'(quot_q) * FREQ_W'(MODULUS));

  always_comb begin
    unique case (idx_q)
      IDX_R5:  word = REG5_WORD;
      IDX_R4:  word = REG4_BASE | {8'b0, code_q, 20'b0};
      IDX_R3:  word = REG3_WORD;
      IDX_R2:  word = REG2_BASE | {8'b0, refd_q, 14'b0};
      IDX_R1:  word = REG1_WORD;
      IDX_R0:  word = {4'b0, quot_q, 2'b0, rem_q, 3'b0};
      default: word = '0;
    endcase
  end

  assign need     = writing_q || (word != shadow_q[idx_q]);
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = ctrl_i.emit && (!need || out_free);
  assign load_out = ctrl_i.emit && need && out_free;

  assign stat_o = '{beat_in: beat_in, emit_more: !(advance && (idx_q == IDX_R0))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refd_q <= REFD_RESET;
    end else if (cfg_we_i) begin
      refd_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_in) begin
      osc_q  <= osc_wide[FREQ_W-1:0];
      code_q <= code_d;
    end
    if (ctrl_i.ld_quot) begin
      quot_q <= prod[DIV_SHIFT +: QUOT_W];
    end
    if (ctrl_i.ld_rem) begin
      rem_q <= rem_full[REM_W-1:0];
    end
    if (load_out) begin
      out_word_q <= word;
      out_idx_q  <= idx_q;
      out_last_q <= (idx_q == IDX_R0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IDX_R5;
      writing_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        shadow_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.ld_rem) begin
        idx_q     <= IDX_R5;
        writing_q <= 1'b0;
      end else if (advance) begin
        idx_q <= idx_q - IDX_W'(1);
      end
      if (load_out) begin
        writing_q        <= 1'b1;
        shadow_q[idx_q]  <= word;
        out_valid_q      <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_idx_o   = out_idx_q;
  assign out_last_o  = out_last_q;

  `PRWG_ASSERT_IMP(a_last_is_reg0, out_valid_q && out_last_q, out_idx_q == IDX_R0)
  `PRWG_ASSERT_NXT(a_shadow_follows, load_out, shadow_q[$past(idx_q)] == $past(word))
  `PRWG_ASSERT_NXT(a_stall_holds_idx, ctrl_i.emit && need && !out_free,
                   idx_q == $past(idx_q))

endmodule

`default_nettype wire

@@ sv/pll_register_word_generator.sv @@
// Top level of the PLL register word generator
//
// Input stream: one beat carries a target output frequency in kHz in
// s_axis_tdata; values above 4400000 are clamped. Output stream: one beat per
// synthesizer register word that must be written, register 5 down to 0, with
// the register number in m_axis_tuser and tlast on register 0. Once one word
// differs from its last written copy, every lower register follows it; an
// item that changes nothing yields no beat.
// cfg_we_i loads the reference counter (reset value 10); it applies to the next
// register 2 word built and, when the value changes, sends registers 2, 1 and 0 out.
// Sequence: accept in one step, two steps for the divide by 1000 (reciprocal
// multiply, then remainder), then one step per register over the six shadow
// registers. With the receiver ready an item passes through one take, two
// divide and six emit steps before the next beat is taken. A receiver stall
// holds the loop on the current register and holds the output beat.
// Reset clears the step counter, the output valid and all six shadow copies,
// so the first item after reset emits all six words.
`default_nettype none

module pll_register_word_generator
  import prwg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // [22:0] frequency_khz, [23] zero
  input  logic              cfg_we_i,
  input  logic [REFD_W-1:0] cfg_wdata_i,    // ref_divider
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [WORD_W-1:0] m_axis_tdata,   // [31:0] reg_word
  output logic [IDX_W-1:0]  m_axis_tuser,   // [2:0] reg_index
  output logic              m_axis_tlast    // last_of_run
);

  ctrl_t ctrl;
  stat_t stat;

  assign s_axis_tready = ctrl.take_in;

  prwg_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  prwg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (s_axis_tvalid),
    .freq_i      (s_axis_tdata[FREQ_W-1:0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_word_o  (m_axis_tdata),
    .out_idx_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
